// File: rtl/fsr_pkg.sv
// ----------------------------------------------------------------------------
// fsr_pkg: shared types and constants of the flow sensor frame receiver
// Frame layout, register indexes, status codes and payload structs.
// ----------------------------------------------------------------------------
package fsr_pkg;

    localparam int FRAME_LEN  = 14;
    localparam int COUNT_W    = $clog2(FRAME_LEN);
    localparam int TIMER_W    = 24;
    localparam int REG_IDX_W  = 1;
    localparam int REG_DATA_W = TIMER_W;

    localparam logic [7:0] HEAD_A = 8'hFE;
    localparam logic [7:0] HEAD_B = 8'h0A;

    // Positions of interest inside the frame.
    localparam logic [COUNT_W-1:0] POS_SUM_FIRST = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] POS_SUM_LAST  = COUNT_W'(11);
    localparam logic [COUNT_W-1:0] POS_LAST      = COUNT_W'(FRAME_LEN - 1);

    localparam logic [TIMER_W-1:0] READING_PERIOD_RESET = TIMER_W'(100000);
    localparam logic [TIMER_W-1:0] COLLECT_TIMEOUT_RESET = TIMER_W'(33333);

    localparam logic [REG_IDX_W-1:0] REG_READING_PERIOD  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_COLLECT_TIMEOUT = REG_IDX_W'(1);

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_HEAD_ERR = 2'd1,
        STATUS_SUM_ERR  = 2'd2,
        STATUS_TIMEOUT  = 2'd3
    } status_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } fsr_item_t;

    typedef struct packed {
        status_t            status;
        logic signed [15:0] flow_x;
        logic signed [15:0] flow_y;
        logic [15:0]        time_span;
        logic [15:0]        distance_word;
        logic [7:0]         quality;
        logic [7:0]         version;
    } fsr_res_t;

endpackage

// File: rtl/fsr_item_if.sv
// ----------------------------------------------------------------------------
// fsr_item_if: input channel of the flow sensor frame receiver
// Carries one received byte or one time tick per request.
// ----------------------------------------------------------------------------
interface fsr_item_if import fsr_pkg::*; ();

    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);

endinterface

// File: rtl/fsr_result_if.sv
// ----------------------------------------------------------------------------
// fsr_result_if: result channel of the flow sensor frame receiver
// Carries the status and decoded fields of one frame per request.
// ----------------------------------------------------------------------------
interface fsr_result_if import fsr_pkg::*; ();

    logic               valid;
    logic               ready;
    status_t            status;
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic [15:0]        time_span;
    logic [15:0]        distance_word;
    logic [7:0]         quality;
    logic [7:0]         version;

    modport source (
        output valid, output status, output flow_x, output flow_y,
        output time_span, output distance_word, output quality, output version,
        input ready
    );
    modport sink (
        input valid, input status, input flow_x, input flow_y,
        input time_span, input distance_word, input quality, input version,
        output ready
    );

endinterface

// File: rtl/fsr_parser.sv
// ----------------------------------------------------------------------------
// fsr_parser: frame gathering, timers and checks
// Updates phase, byte count, frame bytes and running checksum for each
// accepted request and produces at most one result in the same cycle.
// ----------------------------------------------------------------------------
module fsr_parser import fsr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  fsr_item_t          item,
    input  logic [TIMER_W-1:0] reading_period,
    input  logic [TIMER_W-1:0] collect_timeout,
    output logic               res_valid,
    output fsr_res_t           res
);

    typedef enum logic [1:0] {
        PH_WAIT    = 2'b01,
        PH_COLLECT = 2'b10
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [TIMER_W-1:0] wait_timer_reg, wait_timer_next;
    logic [7:0]         xor_reg, xor_next;
    logic [7:0]         frame_reg [FRAME_LEN];

    logic               is_tick;
    logic [TIMER_W-1:0] timer_dec;
    logic               head_ok;
    logic               sum_ok;

    assign is_tick   = (item.mode == MODE_TICK);
    assign timer_dec = wait_timer_reg - TIMER_W'(1);
    assign head_ok   = (frame_reg[0] == HEAD_A) && (frame_reg[1] == HEAD_B);
    assign sum_ok    = (xor_reg == frame_reg[12]);

    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        wait_timer_next = wait_timer_reg;
        xor_next        = xor_reg;
        res_valid       = 1'b0;
        res             = '0;
        res.status      = STATUS_OK;

        if (accept)
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (is_tick)
                    begin
                        if (wait_timer_reg == '0)
                        begin
                            phase_next      = PH_COLLECT;
                            byte_count_next = '0;
                            wait_timer_next = collect_timeout;
                            xor_next        = '0;
                        end
                        else
                        begin
                            wait_timer_next = timer_dec;
                        end
                    end
                end
                PH_COLLECT:
                begin
                    if (is_tick)
                    begin
                        // The timer stops at zero; a count of one or zero runs out now.
                        if (wait_timer_reg <= TIMER_W'(1))
                        begin
                            res_valid       = 1'b1;
                            res.status      = STATUS_TIMEOUT;
                            byte_count_next = '0;
                            wait_timer_next = collect_timeout;
                            xor_next        = '0;
                        end
                        else
                        begin
                            wait_timer_next = timer_dec;
                        end
                    end
                    else if (byte_count_reg == POS_LAST)
                    begin
                        // The tail byte completes the frame and is not checked.
                        res_valid       = 1'b1;
                        byte_count_next = '0;
                        xor_next        = '0;
                        if (!head_ok)
                        begin
                            res.status      = STATUS_HEAD_ERR;
                            wait_timer_next = collect_timeout;
                        end
                        else if (!sum_ok)
                        begin
                            res.status      = STATUS_SUM_ERR;
                            wait_timer_next = collect_timeout;
                        end
                        else
                        begin
                            res.status        = STATUS_OK;
                            res.flow_x        = {frame_reg[3], frame_reg[2]};
                            res.flow_y        = {frame_reg[5], frame_reg[4]};
                            res.time_span     = {frame_reg[7], frame_reg[6]};
                            res.distance_word = {frame_reg[9], frame_reg[8]};
                            res.quality       = frame_reg[10];
                            res.version       = frame_reg[11];
                            phase_next        = PH_WAIT;
                            wait_timer_next   = reading_period;
                        end
                    end
                    else
                    begin
                        byte_count_next = byte_count_reg + COUNT_W'(1);
                        if (byte_count_reg inside {[POS_SUM_FIRST:POS_SUM_LAST]})
                        begin
                            xor_next = xor_reg ^ item.rx_byte;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT;
            byte_count_reg <= '0;
            wait_timer_reg <= '0;
            xor_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            wait_timer_reg <= wait_timer_next;
            xor_reg        <= xor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == PH_COLLECT) && !is_tick)
        begin
            frame_reg[byte_count_reg] <= item.rx_byte;
        end
    end

    a_count_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= POS_LAST)
        else $error("byte count ran past the frame length");

    a_wait_count_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WAIT) |-> (byte_count_reg == '0))
        else $error("byte count not cleared in waiting phase");

    a_error_no_data : assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status != STATUS_OK)) |->
            (res.flow_x == '0 && res.flow_y == '0 && res.time_span == '0 &&
             res.distance_word == '0 && res.quality == '0 && res.version == '0))
        else $error("error result carries frame data");

    a_timeout_on_tick : assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status == STATUS_TIMEOUT)) |-> (accept && is_tick))
        else $error("timeout result without a tick");

    a_ok_leaves_collect : assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status == STATUS_OK)) |=> (phase_reg == PH_WAIT))
        else $error("good frame did not start a waiting period");

endmodule

// File: rtl/fsr_out_buf.sv
// ----------------------------------------------------------------------------
// fsr_out_buf: result register with skid stage
// Holds up to two results so the input side keeps moving while the output
// side stalls, until the skid stage is full.
// ----------------------------------------------------------------------------
module fsr_out_buf import fsr_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  fsr_res_t push_data,
    output logic     space,
    output logic     out_valid,
    input  logic     out_ready,
    output fsr_res_t out_data
);

    logic     out_valid_reg;
    logic     skid_valid_reg;
    fsr_res_t out_data_reg;
    fsr_res_t skid_data_reg;
    logic     pop;

    assign pop       = out_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in front");

    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("result pushed into a full buffer");

    a_skid_moves_up : assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry lost on pop");

endmodule

// File: rtl/flow_sensor_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// flow_sensor_frame_receiver_top: optical flow sensor frame receiver
// Parses 14-byte sensor frames from a byte and tick stream and reports the
// decoded flow fields or an error status.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Carries
// item      in         mode (byte or tick) and rx_byte, one per request
// result    out        status, flow_x, flow_y, time_span, distance_word,
//                      quality, version, one per request
// wr_*      in         register writes: period (index 0), timeout (index 1)
//
// Every request is handled in a single pass and its result, if any, is registered
// on the following cycle: in the result register, or in the skid stage while
// an older result still waits there. One request per cycle is sustained while the skid stage is free.
// The skid stage lets the input keep flowing while the result side stalls;
// item.ready drops only when both stages are full and rises again in the
// cycle after the result side takes a result.
// Reset puts the block in its waiting phase with a zero timer, so the first
// tick starts collecting; the registers return to their reset periods.
// The user must write registers only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module flow_sensor_frame_receiver_top import fsr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    fsr_item_if.sink              item,
    fsr_result_if.source          result,
    input  logic                  wr_en,
    input  logic [REG_IDX_W-1:0]  wr_index,
    input  logic [REG_DATA_W-1:0] wr_data
);

    // Configuration registers. Both are as wide as the write data.
    logic [TIMER_W-1:0] reading_period_reg;
    logic [TIMER_W-1:0] collect_timeout_reg;

    // A request is taken whenever the skid stage is free, since each request
    // makes at most one result.
    logic      accept;
    logic      space;
    fsr_item_t item_bus;
    logic      res_valid;
    fsr_res_t  res;
    fsr_res_t  out_data;

    assign item.ready = space;
    assign accept     = item.valid && space;
    assign item_bus   = '{mode: item.mode, rx_byte: item.rx_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reading_period_reg  <= READING_PERIOD_RESET;
            collect_timeout_reg <= COLLECT_TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_READING_PERIOD:  reading_period_reg  <= wr_data;
                REG_COLLECT_TIMEOUT: collect_timeout_reg <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    // The parser does the whole job for one request in a single pass: phase
    // and timer update, byte capture, running checksum and frame checks.
    fsr_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .item            (item_bus),
        .reading_period  (reading_period_reg),
        .collect_timeout (collect_timeout_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    // Results are registered here before they leave the block.
    fsr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_data)
    );

    assign result.status        = out_data.status;
    assign result.flow_x        = out_data.flow_x;
    assign result.flow_y        = out_data.flow_y;
    assign result.time_span     = out_data.time_span;
    assign result.distance_word = out_data.distance_word;
    assign result.quality       = out_data.quality;
    assign result.version       = out_data.version;

endmodule
